@@ hdl/tlq_pkg.sv @@
// Package for the threshold alarm qualifier: payload types, codes and helpers.
package tlq_pkg;

	localparam int unsigned LEVEL_W   = 32;
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned TOTAL_W   = 32;
	localparam int unsigned TIME_W    = 40;
	localparam int unsigned SPAN_W    = 27;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	typedef enum logic [1:0] {
		ST_NORMAL   = 2'd0,
		ST_WARNING  = 2'd1,
		ST_CRITICAL = 2'd2
	} alarm_state_t;

	typedef enum logic [1:0] {
		EV_WARNING  = 2'd0,
		EV_CRITICAL = 2'd1,
		EV_RECOVERY = 2'd2
	} event_level_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMPARE_BELOW    = 3'd0,
		REG_WARNING_LEVEL    = 3'd1,
		REG_CRITICAL_LEVEL   = 3'd2,
		REG_RECOVERY_LEVEL   = 3'd3,
		REG_WARNING_PERSIST  = 3'd4,
		REG_CRITICAL_PERSIST = 3'd5,
		REG_RECOVERY_PERSIST = 3'd6,
		REG_COOLDOWN_SPAN    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] sample_value;
		logic               force_warning;
		logic               force_critical;
		logic               hold_recovery;
		logic [TIME_W-1:0]  timestamp_ms;
	} in_item_t;

	typedef struct packed {
		event_level_t       event_level;
		logic [COUNT_W-1:0] run_hits;
		logic [TOTAL_W-1:0] all_hits;
		logic [LEVEL_W-1:0] peak_value;
	} out_item_t;

	typedef struct packed {
		logic               compare_below;
		logic [LEVEL_W-1:0] warning_level;
		logic [LEVEL_W-1:0] critical_level;
		logic [LEVEL_W-1:0] recovery_level;
		logic [COUNT_W-1:0] warning_persist;
		logic [COUNT_W-1:0] critical_persist;
		logic [COUNT_W-1:0] recovery_persist;
		logic [SPAN_W-1:0]  cooldown_span;
	} cfg_t;

	function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_inc32(input logic [TOTAL_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

endpackage

@@ hdl/tlq_cfg.sv @@
// Configuration register file for the threshold alarm qualifier.
module tlq_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tlq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlq_pkg::CFG_DAT_W-1:0]     cfg_wdata,
	output tlq_pkg::cfg_t                     cfg
);
	import tlq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{warning_persist: COUNT_W'(1), critical_persist: COUNT_W'(1),
				recovery_persist: COUNT_W'(1), default: '0};
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COMPARE_BELOW:    cfg_q.compare_below    <= cfg_wdata[0];
				REG_WARNING_LEVEL:    cfg_q.warning_level    <= cfg_wdata[LEVEL_W-1:0];
				REG_CRITICAL_LEVEL:   cfg_q.critical_level   <= cfg_wdata[LEVEL_W-1:0];
				REG_RECOVERY_LEVEL:   cfg_q.recovery_level   <= cfg_wdata[LEVEL_W-1:0];
				REG_WARNING_PERSIST:  cfg_q.warning_persist  <= cfg_wdata[COUNT_W-1:0];
				REG_CRITICAL_PERSIST: cfg_q.critical_persist <= cfg_wdata[COUNT_W-1:0];
				REG_RECOVERY_PERSIST: cfg_q.recovery_persist <= cfg_wdata[COUNT_W-1:0];
				REG_COOLDOWN_SPAN:    cfg_q.cooldown_span    <= cfg_wdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/tlq_core.sv @@
// Alarm state, persistence counters and event decision for one sample per step.
module tlq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  tlq_pkg::cfg_t      cfg,
	input  tlq_pkg::in_item_t  item,
	input  logic               step,
	output logic               res_fire,
	output tlq_pkg::out_item_t res
);
	import tlq_pkg::*;

	alarm_state_t       state_q, state_d;
	logic [COUNT_W-1:0] hit_run_q, hit_run_d;
	logic [COUNT_W-1:0] crit_run_q, crit_run_d;
	logic [COUNT_W-1:0] rec_run_q, rec_run_d;
	logic [TOTAL_W-1:0] hit_total_q, hit_total_d;
	logic [LEVEL_W-1:0] peak_q, peak_d;
	logic [TIME_W-1:0]  last_act_q, last_act_d;
	logic               notified_q, notified_d;

	logic               crit_hit, warn_hit, rec_ok, in_cool;
	logic               go_crit, go_warn, rec_path, go_norm;
	logic [COUNT_W-1:0] hit_run_inc, crit_run_inc, rec_run_inc;
	logic [TOTAL_W-1:0] hit_total_inc;
	logic [TIME_W-1:0]  elapsed;
	logic [LEVEL_W-1:0] v;

	assign v = item.sample_value;

	assign crit_hit = (cfg.compare_below ? (v <= cfg.critical_level)
		: (v >= cfg.critical_level)) || item.force_critical;
	assign warn_hit = (cfg.compare_below ? (v <= cfg.warning_level)
		: (v >= cfg.warning_level)) || item.force_warning;
	assign rec_ok = !item.hold_recovery && (cfg.compare_below ? (v >= cfg.recovery_level)
		: (v <= cfg.recovery_level));

	assign hit_run_inc   = sat_inc16(hit_run_q);
	assign crit_run_inc  = sat_inc16(crit_run_q);
	assign rec_run_inc   = sat_inc16(rec_run_q);
	assign hit_total_inc = sat_inc32(hit_total_q);

	// elapsed time wraps at 40 bits; a zero activation time means never activated
	assign elapsed = item.timestamp_ms - last_act_q;
	assign in_cool = (cfg.cooldown_span != '0) && (last_act_q != '0)
		&& (elapsed < TIME_W'(cfg.cooldown_span));

	assign go_crit = crit_hit && (item.force_critical || crit_run_inc >= cfg.critical_persist)
		&& (state_q != ST_CRITICAL);
	assign go_warn = !crit_hit && warn_hit
		&& (item.force_warning || hit_run_inc >= cfg.warning_persist)
		&& (state_q == ST_NORMAL);
	assign rec_path = !crit_hit && !warn_hit && rec_ok && (state_q != ST_NORMAL);
	assign go_norm  = rec_path && (rec_run_inc >= cfg.recovery_persist);

	// next state
	always_comb begin
		state_d     = state_q;
		hit_run_d   = hit_run_q;
		crit_run_d  = crit_run_q;
		rec_run_d   = rec_run_q;
		hit_total_d = hit_total_q;
		last_act_d  = last_act_q;
		notified_d  = notified_q;
		peak_d      = (v > peak_q) ? v : peak_q;
		priority if (crit_hit) begin
			hit_run_d   = hit_run_inc;
			crit_run_d  = crit_run_inc;
			hit_total_d = hit_total_inc;
			rec_run_d   = '0;
			if (go_crit) begin
				state_d    = ST_CRITICAL;
				notified_d = 1'b1;
				last_act_d = item.timestamp_ms;
			end
		end else if (warn_hit) begin
			hit_run_d   = hit_run_inc;
			hit_total_d = hit_total_inc;
			crit_run_d  = '0;
			rec_run_d   = '0;
			if (go_warn) begin
				state_d = ST_WARNING;
				// suppressed warning leaves the notification bookkeeping alone
				if (!in_cool) begin
					notified_d = 1'b1;
					last_act_d = item.timestamp_ms;
				end
			end
		end else if (rec_path) begin
			rec_run_d = rec_run_inc;
			if (go_norm) begin
				state_d    = ST_NORMAL;
				hit_run_d  = '0;
				crit_run_d = '0;
				notified_d = 1'b0;
			end
		end else begin
			hit_run_d  = '0;
			crit_run_d = '0;
			rec_run_d  = '0;
		end
	end

	// event output
	always_comb begin
		res_fire        = 1'b0;
		res.event_level = EV_WARNING;
		if (go_crit) begin
			res_fire        = 1'b1;
			res.event_level = EV_CRITICAL;
		end else if (go_warn && !in_cool) begin
			res_fire        = 1'b1;
			res.event_level = EV_WARNING;
		end else if (go_norm && notified_q) begin
			res_fire        = 1'b1;
			res.event_level = EV_RECOVERY;
		end
		res.run_hits   = hit_run_d;
		res.all_hits   = hit_total_d;
		res.peak_value = peak_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_NORMAL;
			hit_run_q   <= '0;
			crit_run_q  <= '0;
			rec_run_q   <= '0;
			hit_total_q <= '0;
			peak_q      <= '0;
			last_act_q  <= '0;
			notified_q  <= 1'b0;
		end else if (step) begin
			state_q     <= state_d;
			hit_run_q   <= hit_run_d;
			crit_run_q  <= crit_run_d;
			rec_run_q   <= rec_run_d;
			hit_total_q <= hit_total_d;
			peak_q      <= peak_d;
			last_act_q  <= last_act_d;
			notified_q  <= notified_d;
		end
	end

endmodule

@@ hdl/threshold_alarm_qualifier.sv @@
// Threshold alarm qualifier top level: input stage, alarm core and result register.
//
// Usage:
//   Samples enter on the in_valid/in_ready channel as in_item requests. Each one is
//   compared against the critical, warning and recovery levels and may produce one
//   event (warning, critical or recovery) on the out_valid/out_ready channel.
//   Samples that produce no event are consumed silently.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata, one register
//   per cycle, while no request is in flight.
// Pipeline:
//   An accepted request is held in the input stage and is evaluated as it moves
//   into the result register, where an event is registered and shows on out_valid.
//   One request is taken every clock while no result waits on a low out_ready; the
//   alarm core updates its state as each request advances, which sets that rate.
// Reset and stall:
//   arst_n clears the alarm state, counters, peak and all configuration (persistence
//   registers to 1). When out_ready is low with a result waiting, the input stage
//   still takes one more request; in_ready drops only when both stages are full.
module threshold_alarm_qualifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tlq_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tlq_pkg::out_item_t            out_item,
	input  logic                          cfg_wr_en,
	input  logic [tlq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlq_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import tlq_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	logic      res_fire;
	out_item_t out_q;
	logic      out_valid_q;
	logic      advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	tlq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tlq_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.item     (item_s1),
		.step     (advance),
		.res_fire (res_fire),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ hdl/tlq_checker.sv @@
// Port-level checks for the threshold alarm qualifier, bound to the top level.
module tlq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tlq_pkg::out_item_t  out_item
);
	import tlq_pkg::*;

	// a waiting result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped or changed while stalled");

	// a rising result must be traced back to an accepted request
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching request");

	// recovery clears the hit run
	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_level == EV_RECOVERY |-> out_item.run_hits == '0)
		else $error("recovery event with nonzero hit run");

	// with the result register empty the input side never blocks
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

endmodule

bind threshold_alarm_qualifier tlq_checker u_tlq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
